### sv/sbm_pkg.sv
// Shared types, codes and constants of the stack bytecode machine.
`timescale 1ns / 1ps

package sbm_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int CODE_SIZE_DEF   = 1024;

    localparam int DATA_W = 32;
    localparam int BYTE_W = 8;
    localparam int IMM_W  = 24;
    localparam int POS_W  = 10;

    // result word layout on the master tdata bus, lowest bit first
    localparam int POOL_LSB  = 0;
    localparam int INT_LSB   = 8;
    localparam int CODE_LSB  = 40;
    localparam int POS_LSB   = 42;
    localparam int FIELDS_W  = 52;
    localparam int TDATA_W   = 56;
    localparam int TUSER_W   = 3;

    localparam logic [BYTE_W-1:0] OP_PRINT_LIT = 8'd1;
    localparam logic [BYTE_W-1:0] OP_PROMPT    = 8'd2;
    localparam logic [BYTE_W-1:0] OP_PRINT_VAR = 8'd3;
    localparam logic [BYTE_W-1:0] OP_HALT      = 8'd4;
    localparam logic [BYTE_W-1:0] OP_PUSH      = 8'd5;
    localparam logic [BYTE_W-1:0] OP_ADD       = 8'd6;
    localparam logic [BYTE_W-1:0] OP_SUB       = 8'd7;
    localparam logic [BYTE_W-1:0] OP_MUL       = 8'd8;
    localparam logic [BYTE_W-1:0] OP_DIV       = 8'd9;
    localparam logic [BYTE_W-1:0] OP_PRINT_INT = 8'd10;

    typedef enum logic [2:0] {
        EV_LITERAL  = 3'd0,
        EV_PROMPT   = 3'd1,
        EV_VARIABLE = 3'd2,
        EV_INTEGER  = 3'd3,
        EV_HALT     = 3'd4,
        EV_ERROR    = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        ERR_OVERFLOW  = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_DIVZERO   = 2'd2,
        ERR_UNKNOWN   = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_INDEX    = 3'd1,
        PH_IMM1     = 3'd2,
        PH_IMM2     = 3'd3,
        PH_IMM3     = 3'd4,
        PH_IMM_LAST = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_event              kind;
        logic [POS_W-1:0]    pos;
        t_err                code;
        logic [DATA_W-1:0]   value;
        logic [BYTE_W-1:0]   pool;
    } t_result;

endpackage

### sv/sbm_stack_ram.sv
// Operand stack memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module sbm_stack_ram #(
    parameter int DEPTH = sbm_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(sbm_pkg::STACK_DEPTH_DEF)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [sbm_pkg::DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [sbm_pkg::DATA_W-1:0] o_rd_data
);

    logic [sbm_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [sbm_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/sbm_divider.sv
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps

module sbm_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sbm_pkg::DATA_W-1:0] i_dividend,
    input  logic [sbm_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sbm_pkg::DATA_W-1:0] o_quotient
);

    localparam int W  = sbm_pkg::DATA_W;
    localparam int SW = $clog2(W);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [SW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_dvs, n_dvs;
    logic          r_neg, n_neg;
    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
            n_dvs  = i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
            n_neg  = i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            // restoring step: keep the trial remainder when it did not go negative
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (W'(0) - r_quo) : r_quo;

endmodule

### sv/stack_bytecode_machine.sv
// Top level of the stack bytecode machine: decoder, stack sequencer and result stage.
//
//  channel | dir | handshake                     | word
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] code_byte
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tuser event_kind, tdata result fields
//
// Operand, immediate and non-stack opcode bytes are handled in the idle state; an event
// then passes through EMIT into the result stage. Print integer steps through RD1 and
// EMIT; add, subtract and multiply through RD1, RD2 and EXEC (two stack reads through the
// single memory read port, then the write-back); divide adds DIV for the one-bit-per-cycle divider.
// Reset is synchronous and active low; stack contents are not cleared.
// A waiting result does not stop the next byte; only a new event holds the
// sequencer until the output register is free.
`timescale 1ns / 1ps

module stack_bytecode_machine #(
    parameter int STACK_DEPTH = sbm_pkg::STACK_DEPTH_DEF,
    parameter int CODE_SIZE   = sbm_pkg::CODE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] code_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] pool_index, [39:8] int_value, [41:40] error_code, [51:42] error_position
    output logic [sbm_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [sbm_pkg::TUSER_W-1:0] m_axis_tuser    // [2:0] event_kind
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int OW    = $clog2(CODE_SIZE);
    localparam int W     = sbm_pkg::DATA_W;
    localparam int POS_W = sbm_pkg::POS_W;

    sbm_pkg::t_state  r_state, n_state;
    sbm_pkg::t_phase  r_phase, n_phase;
    logic             r_index_kind, n_index_kind;
    logic [sbm_pkg::IMM_W-1:0] r_imm, n_imm;
    logic [CW-1:0]    r_count, n_count;
    logic [OW-1:0]    r_offset, n_offset;
    logic [OW-1:0]    r_op_offset, n_op_offset;
    logic             r_stopped, n_stopped;
    logic [7:0]       r_op, n_op;
    logic [W-1:0]     r_rhs, n_rhs;
    logic [W-1:0]     r_lhs, n_lhs;
    sbm_pkg::t_result r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    sbm_pkg::t_result r_out, n_out;

    logic             w_run;
    logic [7:0]       w_byte;
    logic             w_full, w_lt2, w_empty, w_slot_free;
    logic [CW-1:0]    w_cnt_m1, w_cnt_m2;
    logic [OW+POS_W-1:0] w_here_ext, w_op_pos_ext;
    logic [2*W-1:0]   w_prod;
    logic [W-1:0]     w_alu;

    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr, w_rd_addr;
    logic [W-1:0]     w_wr_data, w_rd_data;
    logic             w_div_start, w_div_done;
    logic [W-1:0]     w_div_quo;

    sbm_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sbm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_lhs),
        .i_divisor  (r_rhs),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign s_axis_tready = (r_state == sbm_pkg::S_IDLE);
    assign w_byte        = s_axis_tdata;
    assign w_run         = s_axis_tvalid && s_axis_tready && !r_stopped;
    assign w_full        = (r_count == CW'(STACK_DEPTH));
    assign w_lt2         = (r_count < CW'(2));
    assign w_empty       = (r_count == '0);
    assign w_cnt_m1      = r_count - CW'(1);
    assign w_cnt_m2      = r_count - CW'(2);
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_here_ext    = {{POS_W{1'b0}}, r_offset};
    assign w_op_pos_ext  = {{POS_W{1'b0}}, r_op_offset};
    assign w_prod        = r_lhs * r_rhs;

    always_comb begin
        case (r_op)
            sbm_pkg::OP_ADD: w_alu = r_lhs + r_rhs;
            sbm_pkg::OP_SUB: w_alu = r_lhs - r_rhs;
            sbm_pkg::OP_MUL: w_alu = w_prod[W-1:0];
            default:         w_alu = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbm_pkg::S_IDLE: begin
                if (w_run) begin
                    case (r_phase)
                        sbm_pkg::PH_INDEX:    n_state = sbm_pkg::S_EMIT;
                        sbm_pkg::PH_IMM_LAST: n_state = w_full ? sbm_pkg::S_EMIT
                                                               : sbm_pkg::S_IDLE;
                        sbm_pkg::PH_OPCODE: begin
                            case (w_byte) inside
                                sbm_pkg::OP_PRINT_LIT, sbm_pkg::OP_PROMPT,
                                sbm_pkg::OP_PUSH:
                                    n_state = sbm_pkg::S_IDLE;
                                [sbm_pkg::OP_ADD:sbm_pkg::OP_DIV]:
                                    n_state = w_lt2 ? sbm_pkg::S_EMIT : sbm_pkg::S_RD1;
                                sbm_pkg::OP_PRINT_INT:
                                    n_state = w_empty ? sbm_pkg::S_EMIT : sbm_pkg::S_RD1;
                                default:
                                    n_state = sbm_pkg::S_EMIT;
                            endcase
                        end
                        default: n_state = sbm_pkg::S_IDLE;
                    endcase
                end
            end
            sbm_pkg::S_RD1: n_state = (r_op == sbm_pkg::OP_PRINT_INT) ? sbm_pkg::S_EMIT
                                                                      : sbm_pkg::S_RD2;
            sbm_pkg::S_RD2: n_state = sbm_pkg::S_EXEC;
            sbm_pkg::S_EXEC: begin
                if (r_op == sbm_pkg::OP_DIV) begin
                    n_state = (r_rhs == '0) ? sbm_pkg::S_EMIT : sbm_pkg::S_DIV;
                end else begin
                    n_state = sbm_pkg::S_IDLE;
                end
            end
            sbm_pkg::S_DIV:  n_state = w_div_done ? sbm_pkg::S_IDLE : sbm_pkg::S_DIV;
            sbm_pkg::S_EMIT: n_state = w_slot_free ? sbm_pkg::S_IDLE : sbm_pkg::S_EMIT;
            default:         n_state = sbm_pkg::S_IDLE;
        endcase
    end

    // datapath, stack access and result
    always_comb begin
        n_phase      = r_phase;
        n_index_kind = r_index_kind;
        n_imm        = r_imm;
        n_count      = r_count;
        n_offset     = r_offset;
        n_op_offset  = r_op_offset;
        n_stopped    = r_stopped;
        n_op         = r_op;
        n_rhs        = r_rhs;
        n_lhs        = r_lhs;
        n_pend       = r_pend;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_count[AW-1:0];
        w_wr_data    = {r_imm, w_byte};
        w_rd_addr    = w_cnt_m1[AW-1:0];
        w_div_start  = 1'b0;

        case (r_state)
            sbm_pkg::S_IDLE: begin
                if (w_run) begin
                    n_offset = (r_offset == OW'(CODE_SIZE - 1)) ? '0 : r_offset + 1'b1;
                    n_pend   = '0;
                    case (r_phase)
                        sbm_pkg::PH_INDEX: begin
                            n_phase     = sbm_pkg::PH_OPCODE;
                            n_pend.kind = r_index_kind ? sbm_pkg::EV_PROMPT
                                                       : sbm_pkg::EV_LITERAL;
                            n_pend.pool = w_byte;
                        end
                        sbm_pkg::PH_IMM1, sbm_pkg::PH_IMM2, sbm_pkg::PH_IMM3: begin
                            n_imm   = {r_imm[sbm_pkg::IMM_W-9:0], w_byte};
                            n_phase = sbm_pkg::t_phase'(r_phase + 3'd1);
                        end
                        sbm_pkg::PH_IMM_LAST: begin
                            n_phase = sbm_pkg::PH_OPCODE;
                            n_imm   = '0;
                            if (w_full) begin
                                n_stopped   = 1'b1;
                                n_pend.kind = sbm_pkg::EV_ERROR;
                                n_pend.code = sbm_pkg::ERR_OVERFLOW;
                                n_pend.pos  = w_op_pos_ext[POS_W-1:0];
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        default: begin
                            n_op_offset = r_offset;
                            n_op        = w_byte;
                            n_pend.code = sbm_pkg::ERR_UNKNOWN;
                            n_pend.pos  = w_here_ext[POS_W-1:0];
                            case (w_byte) inside
                                sbm_pkg::OP_PRINT_LIT, sbm_pkg::OP_PROMPT: begin
                                    n_index_kind = (w_byte == sbm_pkg::OP_PROMPT);
                                    n_phase      = sbm_pkg::PH_INDEX;
                                end
                                sbm_pkg::OP_PRINT_VAR: begin
                                    n_pend.kind = sbm_pkg::EV_VARIABLE;
                                    n_pend.code = sbm_pkg::ERR_OVERFLOW;
                                    n_pend.pos  = '0;
                                end
                                sbm_pkg::OP_HALT: begin
                                    n_stopped   = 1'b1;
                                    n_pend.kind = sbm_pkg::EV_HALT;
                                    n_pend.code = sbm_pkg::ERR_OVERFLOW;
                                    n_pend.pos  = '0;
                                end
                                sbm_pkg::OP_PUSH: begin
                                    n_imm   = '0;
                                    n_phase = sbm_pkg::PH_IMM1;
                                end
                                [sbm_pkg::OP_ADD:sbm_pkg::OP_DIV]: begin
                                    if (w_lt2) begin
                                        n_stopped   = 1'b1;
                                        n_pend.kind = sbm_pkg::EV_ERROR;
                                        n_pend.code = sbm_pkg::ERR_UNDERFLOW;
                                    end
                                end
                                sbm_pkg::OP_PRINT_INT: begin
                                    if (w_empty) begin
                                        n_stopped   = 1'b1;
                                        n_pend.kind = sbm_pkg::EV_ERROR;
                                        n_pend.code = sbm_pkg::ERR_UNDERFLOW;
                                    end else begin
                                        n_count = w_cnt_m1;
                                    end
                                end
                                default: begin
                                    n_stopped   = 1'b1;
                                    n_pend.kind = sbm_pkg::EV_ERROR;
                                end
                            endcase
                        end
                    endcase
                end
            end
            sbm_pkg::S_RD1: begin
                // top of stack arrives; fetch the entry below it for binary ops
                w_rd_addr = w_cnt_m2[AW-1:0];
                n_rhs     = w_rd_data;
                n_pend       = '0;
                n_pend.kind  = sbm_pkg::EV_INTEGER;
                n_pend.value = w_rd_data;
            end
            sbm_pkg::S_RD2: begin
                n_lhs = w_rd_data;
            end
            sbm_pkg::S_EXEC: begin
                w_wr_addr = w_cnt_m2[AW-1:0];
                w_wr_data = w_alu;
                if (r_op == sbm_pkg::OP_DIV) begin
                    if (r_rhs == '0) begin
                        n_count     = w_cnt_m2;
                        n_stopped   = 1'b1;
                        n_pend      = '0;
                        n_pend.kind = sbm_pkg::EV_ERROR;
                        n_pend.code = sbm_pkg::ERR_DIVZERO;
                        n_pend.pos  = w_op_pos_ext[POS_W-1:0];
                    end else begin
                        w_div_start = 1'b1;
                    end
                end else begin
                    w_wr_en = 1'b1;
                    n_count = w_cnt_m1;
                end
            end
            sbm_pkg::S_DIV: begin
                w_wr_addr = w_cnt_m2[AW-1:0];
                w_wr_data = w_div_quo;
                if (w_div_done) begin
                    w_wr_en = 1'b1;
                    n_count = w_cnt_m1;
                end
            end
            default: begin
            end
        endcase

        // result stage: drop a taken word, then load the pending one when free
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == sbm_pkg::S_EMIT && w_slot_free) begin
            n_out_valid = 1'b1;
            n_out       = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sbm_pkg::S_IDLE;
            r_phase      <= sbm_pkg::PH_OPCODE;
            r_index_kind <= 1'b0;
            r_imm        <= '0;
            r_count      <= '0;
            r_offset     <= '0;
            r_op_offset  <= '0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_index_kind <= n_index_kind;
            r_imm        <= n_imm;
            r_count      <= n_count;
            r_offset     <= n_offset;
            r_op_offset  <= n_op_offset;
            r_stopped    <= n_stopped;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_rhs  <= n_rhs;
        r_lhs  <= n_lhs;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {{(sbm_pkg::TDATA_W - sbm_pkg::FIELDS_W){1'b0}},
                            r_out.pos, r_out.code, r_out.value, r_out.pool};

endmodule

### sv/sbm_checker.sv
// Port-level checks on the result stream of the stack bytecode machine, with bind.
`timescale 1ns / 1ps

module sbm_port_checks (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [sbm_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [sbm_pkg::TUSER_W-1:0] m_axis_tuser
);

    logic r_stop_seen;
    logic w_stop_word;

    assign w_stop_word = m_axis_tvalid && m_axis_tready &&
                         (m_axis_tuser == sbm_pkg::EV_HALT ||
                          m_axis_tuser == sbm_pkg::EV_ERROR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_seen <= 1'b0;
        end else if (w_stop_word) begin
            r_stop_seen <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_silent_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_seen |-> !m_axis_tvalid)
        else $error("result word after halt or error");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != sbm_pkg::EV_ERROR |->
            m_axis_tdata[sbm_pkg::FIELDS_W-1:sbm_pkg::CODE_LSB] == '0)
        else $error("error fields set on a non-error word");

    a_int_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != sbm_pkg::EV_INTEGER |->
            m_axis_tdata[sbm_pkg::CODE_LSB-1:sbm_pkg::INT_LSB] == '0)
        else $error("integer field set on a non-integer word");

endmodule

bind stack_bytecode_machine sbm_port_checks u_sbm_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### sim/sbm_checker.sv
// Checker for the stack bytecode machine: predicts events from accepted code bytes and compares.
`timescale 1ns / 1ps

module sbm_checker #(
    parameter int STACK_DEPTH = sbm_pkg::STACK_DEPTH_DEF,
    parameter int CODE_SIZE   = sbm_pkg::CODE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] code_byte
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [7:0] pool_index, [39:8] int_value, [41:40] error_code, [51:42] error_position
    input  logic [sbm_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic [sbm_pkg::TUSER_W-1:0] m_axis_tuser,   // [2:0] event_kind
    output int                          o_fail_count,
    output int                          o_pending
);

    sbm_pkg::t_phase                  phase;
    logic                             want_prompt;
    logic [sbm_pkg::IMM_W-1:0]        imm_bytes;
    logic [sbm_pkg::DATA_W-1:0]       stack_mem [STACK_DEPTH];
    int                               depth;
    int                               offset;
    int                               op_at;
    logic                             halted;
    sbm_pkg::t_result                 events_due[$];
    int                               fails = 0;

    task automatic clear_machine();
        phase       = sbm_pkg::PH_OPCODE;
        want_prompt = 1'b0;
        imm_bytes   = '0;
        depth       = 0;
        offset      = 0;
        op_at       = 0;
        halted      = 1'b0;
    endtask

    task automatic raise_error(input sbm_pkg::t_err code);
        sbm_pkg::t_result r;
        r        = '0;
        r.kind   = sbm_pkg::EV_ERROR;
        r.code   = code;
        r.pos    = sbm_pkg::POS_W'(op_at);
        halted   = 1'b1;
        events_due.push_back(r);
    endtask

    task automatic take_byte(input logic [7:0] b);
        sbm_pkg::t_result           r;
        int                         here;
        logic [sbm_pkg::DATA_W-1:0] lhs;
        logic [sbm_pkg::DATA_W-1:0] rhs;
        logic [sbm_pkg::DATA_W-1:0] res;
        logic [sbm_pkg::DATA_W-1:0] mag_l;
        logic [sbm_pkg::DATA_W-1:0] mag_r;
        logic                       div_zero;
        r        = '0;
        res      = '0;
        div_zero = 1'b0;
        if (halted)
            return;
        here   = offset;
        offset = (offset + 1 >= CODE_SIZE) ? 0 : offset + 1;
        case (phase)
            sbm_pkg::PH_INDEX: begin
                phase  = sbm_pkg::PH_OPCODE;
                r.kind = want_prompt ? sbm_pkg::EV_PROMPT : sbm_pkg::EV_LITERAL;
                r.pool = b;
                events_due.push_back(r);
            end
            sbm_pkg::PH_IMM1, sbm_pkg::PH_IMM2, sbm_pkg::PH_IMM3: begin
                imm_bytes = {imm_bytes[sbm_pkg::IMM_W-9:0], b};
                phase     = sbm_pkg::t_phase'(phase + 3'd1);
            end
            sbm_pkg::PH_IMM_LAST: begin
                phase = sbm_pkg::PH_OPCODE;
                res   = {imm_bytes, b};
                imm_bytes = '0;
                if (depth >= STACK_DEPTH) begin
                    raise_error(sbm_pkg::ERR_OVERFLOW);
                end else begin
                    stack_mem[depth] = res;
                    depth++;
                end
            end
            default: begin
                phase = sbm_pkg::PH_OPCODE;
                op_at = here;
                case (b)
                    sbm_pkg::OP_PRINT_LIT, sbm_pkg::OP_PROMPT: begin
                        want_prompt = (b == sbm_pkg::OP_PROMPT);
                        phase       = sbm_pkg::PH_INDEX;
                    end
                    sbm_pkg::OP_PRINT_VAR: begin
                        r.kind = sbm_pkg::EV_VARIABLE;
                        events_due.push_back(r);
                    end
                    sbm_pkg::OP_HALT: begin
                        halted = 1'b1;
                        r.kind = sbm_pkg::EV_HALT;
                        events_due.push_back(r);
                    end
                    sbm_pkg::OP_PUSH: begin
                        imm_bytes = '0;
                        phase     = sbm_pkg::PH_IMM1;
                    end
                    sbm_pkg::OP_ADD, sbm_pkg::OP_SUB, sbm_pkg::OP_MUL,
                    sbm_pkg::OP_DIV: begin
                        if (depth < 2) begin
                            raise_error(sbm_pkg::ERR_UNDERFLOW);
                        end else begin
                            rhs   = stack_mem[depth-1];
                            lhs   = stack_mem[depth-2];
                            depth = depth - 2;
                            case (b)
                                sbm_pkg::OP_ADD: res = lhs + rhs;
                                sbm_pkg::OP_SUB: res = lhs - rhs;
                                sbm_pkg::OP_MUL: res = lhs * rhs;
                                default: begin
                                    // truncate toward zero on magnitudes; min / -1 wraps
                                    if (rhs == '0) begin
                                        div_zero = 1'b1;
                                    end else begin
                                        mag_l = lhs[sbm_pkg::DATA_W-1] ? -lhs : lhs;
                                        mag_r = rhs[sbm_pkg::DATA_W-1] ? -rhs : rhs;
                                        res   = mag_l / mag_r;
                                        if (lhs[sbm_pkg::DATA_W-1] != rhs[sbm_pkg::DATA_W-1])
                                            res = -res;
                                    end
                                end
                            endcase
                            if (div_zero) begin
                                raise_error(sbm_pkg::ERR_DIVZERO);
                            end else begin
                                stack_mem[depth] = res;
                                depth++;
                            end
                        end
                    end
                    sbm_pkg::OP_PRINT_INT: begin
                        if (depth == 0) begin
                            raise_error(sbm_pkg::ERR_UNDERFLOW);
                        end else begin
                            depth--;
                            r.kind  = sbm_pkg::EV_INTEGER;
                            r.value = stack_mem[depth];
                            events_due.push_back(r);
                        end
                    end
                    default: raise_error(sbm_pkg::ERR_UNKNOWN);
                endcase
            end
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
        fails++;
    endtask

    task automatic check_result();
        sbm_pkg::t_result want;
        sbm_pkg::t_result got;
        got = sbm_pkg::t_result'({m_axis_tuser, m_axis_tdata[sbm_pkg::FIELDS_W-1:0]});
        if (events_due.size() == 0) begin
            $display("%0t unexpected word: expected none, got kind %0d", $time, got.kind);
            fails++;
            return;
        end
        want = events_due.pop_front();
        if (got.kind !== want.kind)
            report("event_kind", 32'(want.kind), 32'(got.kind));
        if (got.pool !== want.pool)
            report("pool_index", 32'(want.pool), 32'(got.pool));
        if (got.value !== want.value)
            report("int_value", want.value, got.value);
        if (got.code !== want.code)
            report("error_code", 32'(want.code), 32'(got.code));
        if (got.pos !== want.pos)
            report("error_position", 32'(want.pos), 32'(got.pos));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_machine();
            events_due.delete();
        end else begin
            // compare first so a stray word is never matched to a byte taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata);
        end
        o_fail_count <= fails;
        o_pending    <= events_due.size();
    end

endmodule

### sim/tb_stack_bytecode_machine.sv
// Testbench top for the stack bytecode machine: clock, reset, bytecode stimulus and verdict.
`timescale 1ns / 1ps

module tb_stack_bytecode_machine;

    localparam int ITEMS          = 1900;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int DEPTH_CAP      = 200;
    localparam int CLOSE_OVERFLOW = 4;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = '0;    // [7:0] code_byte
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [7:0] pool_index, [39:8] int_value, [41:40] error_code, [51:42] error_position
    logic [sbm_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic [sbm_pkg::TUSER_W-1:0]   m_axis_tuser;          // [2:0] event_kind

    int fail_count;
    int pending;
    int n_sent       = 0;
    int n_results    = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int stack_level  = 0;
    logic held_off   = 1'b0;

    stack_bytecode_machine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sbm_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            n_results <= n_results + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: runs of ready and stall, plus one long hold-off to back up the input
    initial begin
        int run;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && n_results >= 4) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 30);
                m_axis_tready <= ($urandom_range(0, 3) != 0);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        n_sent++;
    endtask

    task automatic push_word(input logic [31:0] w);
        send_byte(sbm_pkg::OP_PUSH);
        send_byte(w[31:24]);
        send_byte(w[23:16]);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
        stack_level++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(0, 20));
            1:       return -32'($urandom_range(1, 20));
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int          pick;
        int          close_kind;
        int          reserve;
        logic [31:0] w;
        logic [7:0]  ops [4];
        ops = '{sbm_pkg::OP_ADD, sbm_pkg::OP_SUB, sbm_pkg::OP_MUL, sbm_pkg::OP_DIV};
        close_kind = $urandom_range(0, 4);
        reserve    = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: index extremes, plain events, min / -1 and the largest positive value
        send_byte(sbm_pkg::OP_PRINT_LIT);
        send_byte(8'h00);
        send_byte(sbm_pkg::OP_PROMPT);
        send_byte(8'hFF);
        send_byte(sbm_pkg::OP_PRINT_VAR);
        push_word(32'h8000_0000);
        push_word(32'hFFFF_FFFF);
        send_byte(sbm_pkg::OP_DIV);
        stack_level--;
        send_byte(sbm_pkg::OP_PRINT_INT);
        stack_level--;
        push_word(32'h7FFF_FFFF);
        send_byte(sbm_pkg::OP_PRINT_INT);
        stack_level--;

        // random well-formed programs; no error may occur before the closing sequence
        // leave room for filling the stack when the run closes with an overflow
        while (n_sent + reserve < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (stack_level < 2 || (pick < 35 && stack_level < DEPTH_CAP)) begin
                push_word(pick_word());
            end else if (pick < 65) begin
                send_byte(ops[$urandom_range(0, 2)]);
                stack_level--;
            end else if (pick < 72) begin
                w = pick_word();
                push_word((w == '0) ? 32'd1 : w);
                send_byte(sbm_pkg::OP_DIV);
                stack_level--;
            end else if (pick < 85) begin
                send_byte(sbm_pkg::OP_PRINT_INT);
                stack_level--;
            end else if (pick < 90) begin
                send_byte(sbm_pkg::OP_PRINT_LIT);
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                send_byte(sbm_pkg::OP_PROMPT);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(sbm_pkg::OP_PRINT_VAR);
            end
            if (close_kind == CLOSE_OVERFLOW)
                reserve = 5 * (sbm_pkg::STACK_DEPTH_DEF + 1 - stack_level);
        end

        // close the program with one way of stopping
        case (close_kind)
            0: send_byte(sbm_pkg::OP_HALT);
            1: send_byte(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(11, 255)));
            2: begin
                while (stack_level > 1) begin
                    send_byte(sbm_pkg::OP_PRINT_INT);
                    stack_level--;
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(ops[$urandom_range(0, 3)]);
                end else begin
                    send_byte(sbm_pkg::OP_PRINT_INT);
                    send_byte(($urandom_range(0, 1) == 0) ? sbm_pkg::OP_PRINT_INT
                                                          : ops[$urandom_range(0, 3)]);
                end
            end
            3: begin
                push_word(pick_word());
                push_word(32'd0);
                send_byte(sbm_pkg::OP_DIV);
            end
            default: begin
                while (stack_level < sbm_pkg::STACK_DEPTH_DEF)
                    push_word(pick_word());
                push_word(pick_word());
            end
        endcase

        // stopped: these bytes must be dropped
        repeat (16) send_byte(8'($urandom_range(0, 255)));
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
